// ===== src/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// Shared constants and types of the stream prefix reverser.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

   // block size
   localparam int MAX_PREFIX  = 64;
   localparam int WORD_BITS   = 32;
   localparam int LEN_BITS    = 7;
   localparam int STORE_DEPTH = (MAX_PREFIX > 1) ? MAX_PREFIX - 1 : 1;
   localparam int FILL_BITS   = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
   localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // one emit command: the word, its sequence end and the number of held words
   typedef struct packed {
      logic signed [WORD_BITS-1:0] word;
      logic                        send;
      logic [FILL_BITS-1:0]        count;
   } cmd_type;

   // store write port
   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      logic [WORD_BITS-1:0] data;
   } ram_wr_type;

   // store read port
   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
   } ram_rd_type;

   // back status toward the front
   typedef struct packed {
      logic popping;
      logic run_done;
   } back_stat_type;

endpackage

`default_nettype wire

// ===== src/spr_ram.sv =====
// ----------------------------------------------------------------------------
// spr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 63
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/spr_front.sv =====
// ----------------------------------------------------------------------------
// spr_front
// Accepts input items, keeps the prefix counters, pushes held words into the
// store and queues emit commands for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [spr_pkg::LEN_BITS-1:0]   csr_wr_data,
   input  wire logic                           in_valid,
   output      logic                           in_ready,
   input  wire logic signed [spr_pkg::WORD_BITS-1:0] in_word,
   input  wire logic                           in_send,
   output      spr_pkg::cmd_type               cmd,
   output      logic                           cmd_valid,
   input  wire logic                           cmd_ready,
   output      spr_pkg::ram_wr_type            ram_wr,
   input  wire spr_pkg::back_stat_type         back_stat,
   output      logic                           busy
);
   logic [spr_pkg::LEN_BITS-1:0]  prefix_ff;
   logic [spr_pkg::LEN_BITS-1:0]  seen_ff, seen_in;
   logic [spr_pkg::FILL_BITS-1:0] fill_ff, fill_in;
   logic                          busy_ff, busy_in;
   logic [spr_pkg::LEN_BITS-1:0]  k;
   logic                          accept;
   logic                          do_pass;
   logic                          do_push;
   logic [spr_pkg::LEN_BITS:0]    seen_next;

   // length register
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
      end else if (csr_wr_en) begin
         prefix_ff <= csr_wr_data;
      end
   end

   // length clamped to the bound
   assign k = (prefix_ff > spr_pkg::LEN_BITS'(spr_pkg::MAX_PREFIX))
            ? spr_pkg::LEN_BITS'(spr_pkg::MAX_PREFIX) : prefix_ff;

   // no accept while a run still reads the store
   assign in_ready = cmd_ready && !busy_ff;
   assign accept   = in_valid && in_ready;

   // classify the item
   assign seen_next = {1'b0, seen_ff} + 1'b1;
   assign do_pass   = (seen_ff >= k) && (fill_ff == '0);
   assign do_push   = !do_pass && (seen_next < {1'b0, k}) && !in_send
                    && (fill_ff < spr_pkg::FILL_BITS'(spr_pkg::STORE_DEPTH));

   // counter and busy updates
   always_comb begin
      seen_in = seen_ff;
      fill_in = fill_ff;
      busy_in = busy_ff;
      if (back_stat.run_done) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         priority if (do_pass) begin
            if (in_send) begin
               seen_in = '0;
            end
         end else if (do_push) begin
            fill_in = fill_ff + 1'b1;
            seen_in = seen_next[spr_pkg::LEN_BITS-1:0];
         end else begin
            fill_in = '0;
            seen_in = in_send ? '0 : k;
            busy_in = (fill_ff != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         fill_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         fill_ff <= fill_in;
         busy_ff <= busy_in;
      end
   end

   // store write for held words
   assign ram_wr.en   = accept && do_push;
   assign ram_wr.addr = spr_pkg::ADDR_BITS'(fill_ff);
   assign ram_wr.data = in_word;

   // emit command, a pass is a run with nothing held
   assign cmd_valid = accept && !do_push;
   assign cmd.word  = in_word;
   assign cmd.send  = in_send;
   assign cmd.count = do_pass ? '0 : fill_ff;

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ===== src/spr_queue.sv =====
// ----------------------------------------------------------------------------
// spr_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire spr_pkg::cmd_type push_cmd,
   input  wire logic             push_valid,
   output      logic             push_ready,
   output      spr_pkg::cmd_type pop_cmd,
   output      logic             pop_valid,
   input  wire logic             pop_ready
);
   spr_pkg::cmd_type               slot_ff [spr_pkg::QUEUE_DEPTH];
   logic [spr_pkg::QPTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [spr_pkg::QCNT_BITS-1:0]  cnt_ff;
   logic                           do_push, do_pop;

   assign push_ready = (cnt_ff != spr_pkg::QCNT_BITS'(spr_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   // payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == spr_pkg::QPTR_BITS'(spr_pkg::QUEUE_DEPTH - 1))
                       ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == spr_pkg::QPTR_BITS'(spr_pkg::QUEUE_DEPTH - 1))
                       ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/spr_back.sv =====
// ----------------------------------------------------------------------------
// spr_back
// Carries out emit commands: sends the current word, then pops the held words
// newest first through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire spr_pkg::cmd_type                  cmd,
   input  wire logic                              cmd_valid,
   output      logic                              cmd_ready,
   output      spr_pkg::ram_rd_type               ram_rd,
   input  wire logic [spr_pkg::WORD_BITS-1:0]     ram_data,
   output      spr_pkg::back_stat_type            stat,
   output      logic                              out_valid,
   input  wire logic                              out_ready,
   output      logic signed [spr_pkg::WORD_BITS-1:0] out_word,
   output      logic                              out_run_last,
   output      logic                              out_send
);
   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_POP  = 2'b10
   } back_state_type;

   back_state_type                state_ff, state_in;
   logic [spr_pkg::FILL_BITS-1:0] rem_ff, rem_in;
   logic                          send_ff, send_in;
   logic                          valid_ff, valid_in;
   logic signed [spr_pkg::WORD_BITS-1:0] word_ff, word_in;
   logic                          last_ff, last_in;
   logic                          oseq_ff, oseq_in;
   logic                          out_free;
   logic                          load;

   assign out_free = !valid_ff || out_ready;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      rem_in      = rem_ff;
      send_in     = send_ff;
      word_in     = word_ff;
      last_in     = last_ff;
      oseq_in     = oseq_ff;
      load        = 1'b0;
      cmd_ready   = 1'b0;
      ram_rd.en   = 1'b0;
      ram_rd.addr = '0;
      stat.popping  = (state_ff == BK_POP);
      stat.run_done = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            cmd_ready = out_free;
            if (cmd_valid && out_free) begin
               load    = 1'b1;
               word_in = cmd.word;
               last_in = (cmd.count == '0);
               oseq_in = cmd.send && (cmd.count == '0);
               send_in = cmd.send;
               if (cmd.count != '0) begin
                  ram_rd.en   = 1'b1;
                  ram_rd.addr = spr_pkg::ADDR_BITS'(cmd.count - 1'b1);
                  rem_in      = cmd.count - 1'b1;
                  state_in    = BK_POP;
               end
            end
         end
         BK_POP: begin
            if (out_free) begin
               load    = 1'b1;
               word_in = ram_data;
               last_in = (rem_ff == '0);
               oseq_in = send_ff && (rem_ff == '0);
               if (rem_ff != '0) begin
                  ram_rd.en   = 1'b1;
                  ram_rd.addr = spr_pkg::ADDR_BITS'(rem_ff - 1'b1);
                  rem_in      = rem_ff - 1'b1;
               end else begin
                  stat.run_done = 1'b1;
                  state_in      = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // output valid
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      send_ff <= send_in;
      word_ff <= word_in;
      last_ff <= last_in;
      oseq_ff <= oseq_in;
   end

   assign out_valid    = valid_ff;
   assign out_word     = word_ff;
   assign out_run_last = last_ff;
   assign out_send     = oseq_ff;

endmodule

`default_nettype wire

// ===== src/stream_prefix_reverser.sv =====
// ----------------------------------------------------------------------------
// stream_prefix_reverser
// Reverses the first prefix_length words of each sequence, passes the rest.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata word, tlast sequence_end
//  rsp      out  rsp_tvalid/rsp_tready  tdata out_word, tlast out_sequence_end,
//                                       tuser run_last
//  csr      in   csr_wr_en              csr_wr_data prefix_length
//
//  a held word is written into the store on accept, a passed word is queued;
//  the back sends a run's closing word, then one store read per held word
//  new input items wait from the close until the last held word is loaded
//  into the output register, since the store has one read and one write port
//  reset is synchronous and clears counters, queue and output valid; the
//  store has no clearing pass
//  either side may stall at any time, the output register parts them
// ----------------------------------------------------------------------------
`default_nettype none

module stream_prefix_reverser (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [spr_pkg::LEN_BITS-1:0]      csr_wr_data,   // prefix_length
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic signed [spr_pkg::WORD_BITS-1:0] req_tdata,  // word
   input  wire logic                              req_tlast,     // sequence_end
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic signed [spr_pkg::WORD_BITS-1:0] rsp_tdata,  // out_word
   output      logic                              rsp_tlast,     // out_sequence_end
   output      logic                              rsp_tuser      // run_last
);
   spr_pkg::cmd_type              fr_cmd, bk_cmd;
   logic                          fr_cmd_valid, fr_cmd_ready;
   logic                          bk_cmd_valid, bk_cmd_ready;
   spr_pkg::ram_wr_type           ram_wr;
   spr_pkg::ram_rd_type           ram_rd;
   logic [spr_pkg::WORD_BITS-1:0] ram_data;
   spr_pkg::back_stat_type        back_stat;
   logic                          front_busy;

   // front: classify and hold
   spr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_word     (req_tdata),
      .in_send     (req_tlast),
      .cmd         (fr_cmd),
      .cmd_valid   (fr_cmd_valid),
      .cmd_ready   (fr_cmd_ready),
      .ram_wr      (ram_wr),
      .back_stat   (back_stat),
      .busy        (front_busy)
   );

   // command queue
   spr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (fr_cmd),
      .push_valid (fr_cmd_valid),
      .push_ready (fr_cmd_ready),
      .pop_cmd    (bk_cmd),
      .pop_valid  (bk_cmd_valid),
      .pop_ready  (bk_cmd_ready)
   );

   // lifo store
   spr_ram #(
      .WIDTH (spr_pkg::WORD_BITS),
      .DEPTH (spr_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (ram_data)
   );

   // back: emit and pop
   spr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd          (bk_cmd),
      .cmd_valid    (bk_cmd_valid),
      .cmd_ready    (bk_cmd_ready),
      .ram_rd       (ram_rd),
      .ram_data     (ram_data),
      .stat         (back_stat),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_word     (rsp_tdata),
      .out_run_last (rsp_tuser),
      .out_send     (rsp_tlast)
   );

   // a run only pops while the front holds off new items
   a_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      back_stat.popping |-> front_busy)
      else $error("store popped while front not held");

   // no store write during a pop run
   a_no_write_in_pop: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |-> !back_stat.popping)
      else $error("store written during pop run");

   // end of a pop run shows a run-last item next
   a_run_done_last: assert property (@(posedge clock) disable iff (reset)
      back_stat.run_done |=> (rsp_tvalid && rsp_tuser))
      else $error("run end without run-last item");

endmodule

`default_nettype wire
